FILE: sv/ttd_pkg.sv
// ----------------------------------------------------------------------------
// Touchpad tap and drag detector package
// Shared types and constants for the tap-to-click and tap-drag logic.
// ----------------------------------------------------------------------------
`default_nettype none

package ttd_pkg;

    localparam int unsigned TIMER_W = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_DETECT_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_TIMEOUT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DRAG_WINDOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_STILL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRAG_ENABLE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_CLICK_EN = 3'd5;

    localparam logic [TIMER_W-1:0] TAP_TIMEOUT_RST = 16'd150;
    localparam logic [TIMER_W-1:0] DRAG_WINDOW_RST = 16'd300;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_MOVE  = 2'd1,
        ACT_END   = 2'd2,
        ACT_TICK  = 2'd3
    } t_action;

    typedef struct packed {
        logic               detect_enable;
        logic [TIMER_W-1:0] tap_timeout_ticks;
        logic [TIMER_W-1:0] drag_window_ticks;
        logic               hold_still_during_tap;
        logic               drag_enable;
        logic               right_click_enable;
    } t_cfg;

    typedef struct packed {
        logic press_valid;
        logic release_valid;
        logic button_id;
        logic suppress_movement;
    } t_result;

endpackage

`default_nettype wire

FILE: sv/ttd_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the detector settings written through the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module ttd_cfg_regs
    import ttd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.detect_enable         <= 1'b1;
            r_cfg.tap_timeout_ticks     <= TAP_TIMEOUT_RST;
            r_cfg.drag_window_ticks     <= DRAG_WINDOW_RST;
            r_cfg.hold_still_during_tap <= 1'b0;
            r_cfg.drag_enable           <= 1'b0;
            r_cfg.right_click_enable    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DETECT_ENABLE:  r_cfg.detect_enable         <= i_cfg_data[0];
                REG_TAP_TIMEOUT:    r_cfg.tap_timeout_ticks     <= i_cfg_data[TIMER_W-1:0];
                REG_DRAG_WINDOW:    r_cfg.drag_window_ticks     <= i_cfg_data[TIMER_W-1:0];
                REG_HOLD_STILL:     r_cfg.hold_still_during_tap <= i_cfg_data[0];
                REG_DRAG_ENABLE:    r_cfg.drag_enable           <= i_cfg_data[0];
                REG_RIGHT_CLICK_EN: r_cfg.right_click_enable    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: sv/ttd_core.sv
// ----------------------------------------------------------------------------
// Tap and drag state core
// Holds touch, tap and drag state and works out one event's result.
// ----------------------------------------------------------------------------
`default_nettype none

module ttd_core
    import ttd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_step,
    input  wire logic [1:0] i_action,
    input  wire logic  i_layer,
    output t_result    o_result
);

    logic               r_touch_active, n_touch_active;
    logic               r_tap_pending, n_tap_pending;
    logic               r_in_window, n_in_window;
    logic               r_drag_active, n_drag_active;
    logic               r_held_button, n_held_button;
    logic [TIMER_W-1:0] r_tap_timer, n_tap_timer;
    logic [TIMER_W-1:0] r_window_timer, n_window_timer;
    t_result            res;
    logic               window_fired;
    logic               click_button;

    always_comb begin
        n_touch_active = r_touch_active;
        n_tap_pending  = r_tap_pending;
        n_in_window    = r_in_window;
        n_drag_active  = r_drag_active;
        n_held_button  = r_held_button;
        n_tap_timer    = r_tap_timer;
        n_window_timer = r_window_timer;
        res            = '0;
        window_fired   = 1'b0;
        click_button   = i_cfg.right_click_enable & i_layer;

        case (t_action'(i_action))
            ACT_START: begin
                n_touch_active = 1'b1;
                if (i_cfg.detect_enable) begin
                    if (r_in_window) begin
                        n_in_window   = 1'b0;
                        n_drag_active = 1'b1;
                    end else begin
                        n_tap_timer           = i_cfg.tap_timeout_ticks;
                        n_tap_pending         = 1'b1;
                        res.suppress_movement = i_cfg.hold_still_during_tap;
                    end
                end
            end
            ACT_MOVE: begin
                res.suppress_movement = i_cfg.detect_enable & r_tap_pending
                                        & i_cfg.hold_still_during_tap;
            end
            ACT_END: begin
                n_touch_active = 1'b0;
                if (r_drag_active) begin
                    res.release_valid = 1'b1;
                    res.button_id     = r_held_button;
                    n_drag_active     = 1'b0;
                end
            end
            ACT_TICK: begin
                // A timer that reads zero or one expires on this tick.
                if (r_in_window) begin
                    if (r_window_timer <= TIMER_W'(1)) begin
                        n_window_timer    = '0;
                        n_in_window       = 1'b0;
                        res.release_valid = 1'b1;
                        res.button_id     = r_held_button;
                        window_fired      = 1'b1;
                    end else begin
                        n_window_timer = r_window_timer - TIMER_W'(1);
                    end
                end
                if (r_tap_pending && !window_fired) begin
                    if (r_tap_timer <= TIMER_W'(1)) begin
                        n_tap_timer   = '0;
                        n_tap_pending = 1'b0;
                        if (!r_touch_active) begin
                            res.press_valid = 1'b1;
                            res.button_id   = click_button;
                            if (i_cfg.drag_enable) begin
                                n_held_button  = click_button;
                                n_in_window    = 1'b1;
                                n_window_timer = i_cfg.drag_window_ticks;
                            end else begin
                                res.release_valid = 1'b1;
                            end
                        end
                    end else begin
                        n_tap_timer = r_tap_timer - TIMER_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touch_active <= 1'b0;
            r_tap_pending  <= 1'b0;
            r_in_window    <= 1'b0;
            r_drag_active  <= 1'b0;
            r_held_button  <= 1'b0;
            r_tap_timer    <= '0;
            r_window_timer <= '0;
        end else if (i_step) begin
            r_touch_active <= n_touch_active;
            r_tap_pending  <= n_tap_pending;
            r_in_window    <= n_in_window;
            r_drag_active  <= n_drag_active;
            r_held_button  <= n_held_button;
            r_tap_timer    <= n_tap_timer;
            r_window_timer <= n_window_timer;
        end
    end

    assign o_result = res;

endmodule

`default_nettype wire

FILE: sv/touchpad_tap_drag_detector.sv
// ----------------------------------------------------------------------------
// Touchpad tap and drag detector
// Turns touch and tick events into tap clicks, drag holds and motion masks.
// ----------------------------------------------------------------------------
// Usage: each input word carries one event (touch start, move, end or a
// one-millisecond tick) and the state of the right-click layer. Every word
// gives exactly one output word with press, release, button and motion
// suppression flags. Both channels use valid and ready.
// The event is registered on acceptance; when the output register is free,
// the state core updates its flags and timers and the result is captured in
// the output register, where the receiver takes it. One word can be accepted
// in every cycle while the receiver does not stall; the state core updates in
// the same cycle that the event moves into the output register.
// When the receiver stalls, the output register holds its word and the input
// register keeps one more event, after which input ready drops.
// Reset clears the touch, tap and drag state, empties both registers and
// loads the default settings. The user writes settings through the plain
// write port while no event is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module touchpad_tap_drag_detector
    import ttd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [1:0]            i_action,
    input  wire logic                  i_right_layer_active,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_press_valid,
    output logic                       o_release_valid,
    output logic                       o_button_id,
    output logic                       o_suppress_movement
);

    t_cfg       cfg;
    t_result    result;
    logic       advance;
    logic       r_in_valid;
    logic [1:0] r_action;
    logic       r_layer;
    logic       r_out_valid;
    t_result    r_out;

    ttd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // The registered event moves into the output register, and updates the
    // state, whenever the output register is empty or being drained.
    assign advance    = r_in_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_in_valid | advance;

    ttd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_step   (advance),
        .i_action (r_action),
        .i_layer  (r_layer),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_action <= i_action;
            r_layer  <= i_right_layer_active;
        end
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_press_valid       = r_out.press_valid;
    assign o_release_valid     = r_out.release_valid;
    assign o_button_id         = r_out.button_id;
    assign o_suppress_movement = r_out.suppress_movement;

endmodule

`default_nettype wire
